// ----- rtl/hcbp_pkg.sv -----
package hcbp_pkg;

   // Request operation codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // Codebook geometry and code word width
   localparam int SYM_BITS     = 8;
   localparam int BOOK_DEPTH   = 1 << SYM_BITS;
   localparam int WORD_BITS    = 32;
   localparam int LEN_BITS     = 6;
   localparam int MAX_CODE_LEN = 32;

endpackage

// ----- rtl/huffman_code_bit_packer_core.sv -----
// Channel    Direction  Handshake            Payload
// request    in         req_valid/req_ready  req_operation, req_symbol, req_code_word,
//                                            req_code_length
// response   out        rsp_valid/rsp_ready  rsp_out_byte, rsp_last
//
// Load writes the codebook and leaves the block ready. Encode emits n bytes (0 to 4):
// codebook read, justify shift, merge shift, one byte per cycle through the shared
// byte shifter unless the response stalls, then storing the remainder. A zero-length
// code ends after the codebook read. Finish sends any partial byte, then the pad count.
// Reset clears the pending bits and all code lengths (valid bits) at once.
// A stalled response holds the byte shifter; the block accepts no request while busy.
module huffman_code_bit_packer_core #(
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_operation,
   input  logic [hcbp_pkg::SYM_BITS-1:0]  req_symbol,
   input  logic [hcbp_pkg::WORD_BITS-1:0] req_code_word,
   input  logic [hcbp_pkg::LEN_BITS-1:0]  req_code_length,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last
);

   localparam int CapInt = (MAX_CODE_LEN < hcbp_pkg::WORD_BITS) ? MAX_CODE_LEN
                                                                 : hcbp_pkg::WORD_BITS;
   localparam logic [hcbp_pkg::LEN_BITS-1:0] LenCap = hcbp_pkg::LEN_BITS'(CapInt);
   localparam int WinBits = hcbp_pkg::WORD_BITS + 8;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ALIGN = 6'b000010,
      ST_MERGE = 6'b000100,
      ST_EMIT  = 6'b001000,
      ST_PADB  = 6'b010000,
      ST_PADC  = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   logic [hcbp_pkg::WORD_BITS-1:0]    code_mem_ff [hcbp_pkg::BOOK_DEPTH];
   logic [hcbp_pkg::LEN_BITS-1:0]     len_mem_ff  [hcbp_pkg::BOOK_DEPTH];
   logic [hcbp_pkg::BOOK_DEPTH-1:0]   len_vld_ff, len_vld_in;
   logic [hcbp_pkg::WORD_BITS-1:0]    code_rd_ff;
   logic [hcbp_pkg::LEN_BITS-1:0]     len_rd_ff;
   logic                              vld_rd_ff;
   logic [hcbp_pkg::WORD_BITS-1:0]    just_ff, just_in;
   logic [WinBits-1:0]                win_ff, win_in;
   logic [5:0]                        cnt_ff, cnt_in;
   logic [6:0]                        pend_ff, pend_in;
   logic [2:0]                        fill_ff, fill_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        rsp_byte_ff, rsp_byte_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              req_fire, load_wr, out_free;
   logic [hcbp_pkg::LEN_BITS-1:0]     load_len, enc_len;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign load_wr      = req_fire && (req_operation == hcbp_pkg::OP_LOAD);
   assign load_len     = (req_code_length > LenCap) ? LenCap : req_code_length;
   assign enc_len      = vld_rd_ff ? len_rd_ff : '0;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // Write the codebook on load, read it for every request
   always_ff @(posedge clock) begin
      if (load_wr) begin
         code_mem_ff[req_symbol] <= req_code_word;
         len_mem_ff[req_symbol]  <= load_len;
      end
      code_rd_ff <= code_mem_ff[req_symbol];
      len_rd_ff  <= len_mem_ff[req_symbol];
      vld_rd_ff  <= len_vld_ff[req_symbol];
   end

   // Sequencer and shared byte shifter
   always_comb begin
      state_in     = state_ff;
      len_vld_in   = len_vld_ff;
      just_in      = just_ff;
      win_in       = win_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_wr) begin
         len_vld_in[req_symbol] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_operation == hcbp_pkg::OP_ENCODE) begin
                  state_in = ST_ALIGN;
               end else if (req_operation == hcbp_pkg::OP_FINISH) begin
                  state_in = (fill_ff != 3'd0) ? ST_PADB : ST_PADC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ALIGN: begin
            // Left-justify the code, dropping bits above its length
            if (enc_len == '0) begin
               state_in = ST_IDLE;
            end else begin
               just_in  = code_rd_ff << (6'd32 - enc_len);
               cnt_in   = {3'd0, fill_ff} + enc_len;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            // Append the code below the pending bits
            win_in   = {pend_ff, {(WinBits-7){1'b0}}} | ({just_ff, 8'd0} >> fill_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cnt_ff >= 6'd8) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = win_ff[WinBits-1 -: 8];
                  rsp_last_in  = (cnt_ff < 6'd16);
                  win_in       = win_ff << 8;
                  cnt_in       = cnt_ff - 6'd8;
               end
            end else begin
               pend_in  = win_ff[WinBits-1 -: 7];
               fill_in  = cnt_ff[2:0];
               state_in = ST_IDLE;
            end
         end
         ST_PADB: begin
            // Flush the partial byte, zeros below
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = {pend_ff, 1'b0};
               rsp_last_in  = 1'b0;
               state_in     = ST_PADC;
            end
         end
         ST_PADC: begin
            // Send the pad count and clear the accumulator
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = {5'd0, 3'(4'd8 - {1'b0, fill_ff})};
               rsp_last_in  = 1'b1;
               pend_in      = '0;
               fill_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_vld_ff   <= '0;
         pend_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_vld_ff   <= len_vld_in;
         pend_ff      <= pend_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      just_ff     <= just_in;
      win_ff      <= win_in;
      cnt_ff      <= cnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ----- rtl/hcbp_checker.sv -----
module hcbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_operation,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled response changed");

   // A load completes in the cycle it is accepted
   a_load_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == hcbp_pkg::OP_LOAD) |=> req_ready)
      else $error("load left the block busy");

   // Encode and finish occupy the block
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == hcbp_pkg::OP_ENCODE ||
                                 req_operation == hcbp_pkg::OP_FINISH) |=> !req_ready)
      else $error("block ready right after encode or finish");

   // More bytes pending means no new request
   a_mid_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken with a response sequence open");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last      (rsp_last)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   // Operation code that the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Stored code length saturates to the narrower of the length limit and the word width
   localparam int CODE_CAP = (hcbp_pkg::MAX_CODE_LEN < hcbp_pkg::WORD_BITS)
                             ? hcbp_pkg::MAX_CODE_LEN : hcbp_pkg::WORD_BITS;
   // Cycles to keep the response side blocked during the fill-up test
   localparam int LONG_HOLD = 250;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } packed_byte_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [1:0]                      req_operation = '0;
   logic [hcbp_pkg::SYM_BITS-1:0]   req_symbol = '0;
   logic [hcbp_pkg::WORD_BITS-1:0]  req_code_word = '0;
   logic [hcbp_pkg::LEN_BITS-1:0]   req_code_length = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [7:0]                      rsp_out_byte;
   logic                            rsp_last;

   // Shadow of the codebook and the pending bits
   logic [hcbp_pkg::WORD_BITS-1:0]  code_book [hcbp_pkg::BOOK_DEPTH];
   logic [hcbp_pkg::LEN_BITS-1:0]   code_len [hcbp_pkg::BOOK_DEPTH];
   logic [6:0]                      acc_bits;
   logic [2:0]                      acc_fill;
   logic [hcbp_pkg::BOOK_DEPTH-1:0] loaded_mask;
   logic [7:0]                      loaded_syms [$];

   packed_byte_type       expected_bytes [$];
   int                    mismatch_count = 0;
   bit                    idle_on = 1'b1;
   int                    hold_cycles = 0;

   huffman_code_bit_packer_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // Work out the bytes that one accepted request produces and queue them
   function automatic void pack_request(input logic [1:0] op, input logic [7:0] sym,
                                        input logic [31:0] word, input logic [5:0] len);
      int          l;
      int          total;
      int          n;
      int          pad;
      logic [63:0] acc64;
      logic [63:0] mask;
      logic [7:0]  bytes [4];
      unique case (op)
         hcbp_pkg::OP_LOAD: begin
            l = (len > CODE_CAP) ? CODE_CAP : len;
            mask = (64'd1 << l) - 64'd1;
            code_book[sym] = word & mask[31:0];
            code_len[sym] = l[hcbp_pkg::LEN_BITS-1:0];
            if (!loaded_mask[sym]) begin
               loaded_mask[sym] = 1'b1;
               loaded_syms.push_back(sym);
            end
         end
         hcbp_pkg::OP_ENCODE: begin
            l = code_len[sym];
            if (l != 0) begin
               mask = (64'd1 << l) - 64'd1;
               acc64 = ({57'd0, acc_bits} << l) | ({32'd0, code_book[sym]} & mask);
               total = acc_fill + l;
               n = 0;
               while (total >= 8 && n < 4) begin
                  bytes[n] = 8'(acc64 >> (total - 8));
                  total -= 8;
                  n++;
               end
               for (int i = 0; i < n; i++)
                  expected_bytes.push_back('{out_byte: bytes[i], last: (i == n - 1)});
               mask = (64'd1 << total) - 64'd1;
               acc_bits = acc64[6:0] & mask[6:0];
               acc_fill = total[2:0];
            end
         end
         hcbp_pkg::OP_FINISH: begin
            pad = 0;
            if (acc_fill != 0) begin
               pad = 8 - acc_fill;
               expected_bytes.push_back('{out_byte: ({1'b0, acc_bits} << pad), last: 1'b0});
            end
            expected_bytes.push_back('{out_byte: pad[7:0], last: 1'b1});
            acc_bits = '0;
            acc_fill = '0;
         end
         default: begin
         end
      endcase
   endfunction

   // Offer one request, after an optional random gap, and hold it until accepted
   task automatic send_request(input logic [1:0] op, input logic [7:0] sym,
                               input logic [31:0] word, input logic [5:0] len);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_operation = op;
      req_symbol = sym;
      req_code_word = word;
      req_code_length = len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pack_request(op, sym, word, len);
   endtask

   // Drop the request, then wait for every expected byte
   task automatic wait_drained;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // Mostly short codes, with empty, full-width and over-limit lengths mixed in
   function automatic logic [5:0] pick_length;
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 6'd0;
      if (r == 1) return 6'($urandom_range(33, 63));
      if (r == 2) return 6'd32;
      if (r < 6) return 6'($urandom_range(9, 31));
      return 6'($urandom_range(1, 8));
   endfunction

   function automatic logic [7:0] pick_loaded;
      return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
   endfunction

   task automatic load_random;
      send_request(hcbp_pkg::OP_LOAD, 8'($urandom_range(0, 255)), $urandom, pick_length());
   endtask

   // Well-formed streams (load, encode runs, finish) with some noise in between
   task automatic run_streams(input int n_items);
      int sent;
      int r;
      int k;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 9);
         if (r < 2 || loaded_syms.size() == 0) begin
            load_random();
            sent++;
         end else if (r < 8) begin
            k = $urandom_range(1, 10);
            repeat (k) send_request(hcbp_pkg::OP_ENCODE, pick_loaded(), $urandom, 6'($urandom));
            sent += k;
            if ($urandom_range(0, 3) != 0) begin
               send_request(hcbp_pkg::OP_FINISH, 8'($urandom), $urandom, 6'($urandom));
               sent++;
            end
         end else if (r == 8) begin
            send_request(hcbp_pkg::OP_FINISH, 8'($urandom), $urandom, 6'($urandom));
            sent++;
         end else begin
            send_request(OP_UNUSED, 8'($urandom), $urandom, 6'($urandom));
            sent++;
         end
      end
   endtask

   task automatic test_directed;
      // finish on an empty accumulator gives only the pad count byte
      send_request(hcbp_pkg::OP_FINISH, 8'h00, 32'h0, 6'd0);
      send_request(hcbp_pkg::OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd1);
      send_request(hcbp_pkg::OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
      send_request(hcbp_pkg::OP_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd0);
      send_request(hcbp_pkg::OP_LOAD, 8'h02, 32'h8000_0001, 6'd63);
      send_request(hcbp_pkg::OP_LOAD, 8'h03, 32'hC3A5_5A3C, 6'd40);
      send_request(hcbp_pkg::OP_LOAD, 8'h04, 32'hFFFF_FFA5, 6'd8);
      send_request(hcbp_pkg::OP_LOAD, 8'h05, 32'h0000_0055, 6'd7);
      send_request(hcbp_pkg::OP_LOAD, 8'h06, 32'h0000_0000, 6'd13);
      // a full-width code emits four bytes
      send_request(hcbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);
      // one pending bit, padded with seven zeros
      send_request(hcbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
      send_request(hcbp_pkg::OP_FINISH, 8'h00, 32'h0, 6'd0);
      // zero-length symbol emits nothing
      send_request(hcbp_pkg::OP_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'h3F);
      // seven plus one bits make one exact byte, then finish sees nothing pending
      send_request(hcbp_pkg::OP_ENCODE, 8'h05, 32'h0, 6'd0);
      send_request(hcbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
      send_request(hcbp_pkg::OP_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      // saturated lengths, with pending bits carried across
      send_request(hcbp_pkg::OP_ENCODE, 8'h00, 32'h0, 6'd0);
      send_request(hcbp_pkg::OP_ENCODE, 8'h02, 32'h0, 6'd0);
      send_request(hcbp_pkg::OP_ENCODE, 8'h03, 32'h0, 6'd0);
      send_request(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      send_request(hcbp_pkg::OP_ENCODE, 8'h04, 32'h0, 6'd0);
      send_request(hcbp_pkg::OP_ENCODE, 8'h06, 32'h0, 6'd0);
      send_request(hcbp_pkg::OP_FINISH, 8'h00, 32'h0, 6'd0);
      wait_drained();
   endtask

   task automatic test_random;
      run_streams(190);
      wait_drained();
   endtask

   // Block the response side while long codes keep arriving
   task automatic test_fill_up;
      send_request(hcbp_pkg::OP_LOAD, 8'h10, $urandom, 6'd32);
      send_request(hcbp_pkg::OP_LOAD, 8'h11, $urandom, 6'd31);
      send_request(hcbp_pkg::OP_LOAD, 8'h12, $urandom, 6'd25);
      @(negedge clock);
      req_valid = 1'b0;
      hold_cycles = LONG_HOLD;
      repeat (30) begin
         send_request(hcbp_pkg::OP_ENCODE, 8'($urandom_range(16, 18)), $urandom,
                      6'($urandom));
      end
      send_request(hcbp_pkg::OP_FINISH, 8'h00, 32'h0, 6'd0);
      wait_drained();
   endtask

   task automatic test_no_idle;
      idle_on = 1'b0;
      run_streams(60);
      send_request(hcbp_pkg::OP_FINISH, 8'h00, 32'h0, 6'd0);
   endtask

   // Response side: random stall bursts, plus the long hold when asked
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Compare each accepted response with the oldest expected byte
   always @(posedge clock) begin
      packed_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected response byte", rsp_out_byte, 8'h00);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_last !== want.last)
               report_mismatch("last", {7'd0, rsp_last}, {7'd0, want.last});
         end
      end
   end

   initial begin
      int waited;
      acc_bits = '0;
      acc_fill = '0;
      loaded_mask = '0;
      for (int i = 0; i < hcbp_pkg::BOOK_DEPTH; i++) begin
         code_book[i] = '0;
         code_len[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random();
      test_fill_up();
      test_no_idle();

      @(negedge clock);
      req_valid = 1'b0;
      waited = 0;
      while (expected_bytes.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      while (expected_bytes.size() != 0) begin
         report_mismatch("missing response byte", 8'h00, expected_bytes[0].out_byte);
         void'(expected_bytes.pop_front());
      end
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
